// ===== sv/rcsm_pkg.sv =====
`default_nettype none
package rcsm_pkg;

  localparam logic [1:0] OP_REASSIGN = 2'd0;
  localparam logic [1:0] OP_COLLECT  = 2'd1;
  localparam logic [1:0] OP_READ     = 2'd2;

  localparam logic [1:0] KIND_STATUS  = 2'd0;
  localparam logic [1:0] KIND_SLOT    = 2'd1;
  localparam logic [1:0] KIND_COLLECT = 2'd2;

  localparam int OP_W   = 2;
  localparam int IDX_W  = 4;
  localparam int IN_AW  = 32;
  localparam int OUT_AW = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_OLD,
    ST_SCAN,
    ST_WRITE,
    ST_RD_SLOT,
    ST_COLLECT
  } state_t;

endpackage
`default_nettype wire

// ===== sv/reference_count_slot_manager_core.sv =====
// Pointer-slot manager with reference counting. A request is taken when start is high and
// busy is low; results come out one per cycle on strobe and must be taken as they appear.
// A collect of n queued addresses gives them out one address a cycle. In a reassign, the
// reference count of the released address is the number of other slots still holding it,
// found by a scan of the slot memory, one entry per cycle through its single read port;
// a reassign of a slot holding null skips the scan. A slot index at or beyond SLOTS gets
// address 0 and busy stays low. Operation code 3 is dropped.
`default_nettype none
module reference_count_slot_manager_core
  import rcsm_pkg::*;
#(
  parameter int SLOTS         = 16,
  parameter int GARBAGE_DEPTH = 32,
  parameter int ADDRESS_WIDTH = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [OP_W-1:0]   operation,
  input  wire logic [IDX_W-1:0]  slot_index,
  input  wire logic [IN_AW-1:0]  new_address,
  output logic                   strobe,
  output logic [1:0]             result_kind,
  output logic [OUT_AW-1:0]      address,
  output logic                   queue_full,
  output logic                   queue_empty,
  output logic                   last
);

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int QW = (GARBAGE_DEPTH > 1) ? $clog2(GARBAGE_DEPTH) : 1;
  localparam int FW = $clog2(GARBAGE_DEPTH + 1);
  localparam int AW = ADDRESS_WIDTH;

  logic [AW-1:0] slot_mem [SLOTS];
  logic [SLOTS-1:0] slot_valid;
  logic [AW-1:0] slot_q;
  logic          slot_vq;
  logic [AW-1:0] slot_data;

  logic [AW-1:0] queue_mem [GARBAGE_DEPTH];
  logic [AW-1:0] queue_q;

  state_t        state, state_next;
  logic [SW-1:0] idx_r, idx_r_next;
  logic [AW-1:0] naddr_r, naddr_r_next;
  logic [AW-1:0] old_r, old_r_next;
  logic          found, found_next;
  logic [SW-1:0] cmp_idx, cmp_idx_next;
  logic [FW-1:0] q_cnt, q_cnt_next;
  logic [FW-1:0] fill, fill_next;

  logic              strobe_next;
  logic [1:0]        result_kind_next;
  logic [OUT_AW-1:0] address_next;
  logic              queue_full_next;
  logic              queue_empty_next;
  logic              last_next;

  logic          slot_re, slot_we;
  logic [SW-1:0] slot_raddr;
  logic          q_re, q_we;
  logic [QW-1:0] q_raddr;

  logic          idx_ok;
  logic [SW-1:0] idx_in;
  logic [AW-1:0] naddr_in;
  logic          hit;

  assign idx_ok    = (32'(slot_index) < SLOTS);
  assign idx_in    = SW'(slot_index);
  assign naddr_in  = AW'(new_address);
  assign slot_data = slot_vq ? slot_q : '0;
  assign hit       = (slot_data == old_r) && (cmp_idx != idx_r);
  assign busy      = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (slot_re) begin
      slot_q  <= slot_mem[slot_raddr];
      slot_vq <= slot_valid[slot_raddr];
    end
    if (slot_we) begin
      slot_mem[idx_r] <= naddr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (slot_we) begin
      slot_valid[idx_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_re) begin
      queue_q <= queue_mem[q_raddr];
    end
    if (q_we) begin
      queue_mem[fill[QW-1:0]] <= old_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      fill   <= '0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      fill   <= fill_next;
      strobe <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_r_next;
    naddr_r     <= naddr_r_next;
    old_r       <= old_r_next;
    found       <= found_next;
    cmp_idx     <= cmp_idx_next;
    q_cnt       <= q_cnt_next;
    result_kind <= result_kind_next;
    address     <= address_next;
    queue_full  <= queue_full_next;
    queue_empty <= queue_empty_next;
    last        <= last_next;
  end

  always_comb begin
    state_next       = state;
    idx_r_next       = idx_r;
    naddr_r_next     = naddr_r;
    old_r_next       = old_r;
    found_next       = found;
    cmp_idx_next     = cmp_idx;
    q_cnt_next       = q_cnt;
    fill_next        = fill;
    strobe_next      = 1'b0;
    result_kind_next = result_kind;
    address_next     = address;
    queue_full_next  = queue_full;
    queue_empty_next = queue_empty;
    last_next        = last;
    slot_re          = 1'b0;
    slot_raddr       = idx_in;
    slot_we          = 1'b0;
    q_re             = 1'b0;
    q_raddr          = '0;
    q_we             = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          case (operation)
            OP_REASSIGN: begin
              if (!idx_ok) begin
                strobe_next      = 1'b1;
                result_kind_next = KIND_STATUS;
                address_next     = '0;
                queue_full_next  = 1'b0;
                queue_empty_next = 1'b0;
                last_next        = 1'b1;
              end else begin
                idx_r_next   = idx_in;
                naddr_r_next = naddr_in;
                slot_re      = 1'b1;
                slot_raddr   = idx_in;
                state_next   = ST_RD_OLD;
              end
            end
            OP_COLLECT: begin
              if (fill == '0) begin
                strobe_next      = 1'b1;
                result_kind_next = KIND_COLLECT;
                address_next     = '0;
                queue_full_next  = 1'b0;
                queue_empty_next = 1'b1;
                last_next        = 1'b1;
              end else begin
                q_re       = 1'b1;
                q_raddr    = '0;
                q_cnt_next = FW'(1);
                state_next = ST_COLLECT;
              end
            end
            OP_READ: begin
              if (!idx_ok) begin
                strobe_next      = 1'b1;
                result_kind_next = KIND_SLOT;
                address_next     = '0;
                queue_full_next  = 1'b0;
                queue_empty_next = 1'b0;
                last_next        = 1'b1;
              end else begin
                slot_re    = 1'b1;
                slot_raddr = idx_in;
                state_next = ST_RD_SLOT;
              end
            end
            default: ;
          endcase
        end
      end
      ST_RD_SLOT: begin
        strobe_next      = 1'b1;
        result_kind_next = KIND_SLOT;
        address_next     = OUT_AW'(slot_data);
        queue_full_next  = 1'b0;
        queue_empty_next = 1'b0;
        last_next        = 1'b1;
        state_next       = ST_IDLE;
      end
      ST_RD_OLD: begin
        old_r_next = slot_data;
        found_next = 1'b0;
        if (slot_data == '0) begin
          state_next = ST_WRITE;
        end else begin
          slot_re      = 1'b1;
          slot_raddr   = '0;
          cmp_idx_next = '0;
          state_next   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        found_next = found | hit;
        if (cmp_idx == SW'(SLOTS - 1)) begin
          state_next = ST_WRITE;
        end else begin
          slot_re      = 1'b1;
          slot_raddr   = cmp_idx + SW'(1);
          cmp_idx_next = cmp_idx + SW'(1);
        end
      end
      ST_WRITE: begin
        slot_we          = 1'b1;
        queue_full_next  = 1'b0;
        // old address dies when no other slot still holds it
        if (old_r != '0 && !found) begin
          if (fill < FW'(GARBAGE_DEPTH)) begin
            q_we      = 1'b1;
            fill_next = fill + FW'(1);
          end else begin
            queue_full_next = 1'b1;
          end
        end
        strobe_next      = 1'b1;
        result_kind_next = KIND_STATUS;
        address_next     = OUT_AW'(naddr_r);
        queue_empty_next = 1'b0;
        last_next        = 1'b1;
        state_next       = ST_IDLE;
      end
      ST_COLLECT: begin
        strobe_next      = 1'b1;
        result_kind_next = KIND_COLLECT;
        address_next     = OUT_AW'(queue_q);
        queue_full_next  = 1'b0;
        queue_empty_next = 1'b0;
        last_next        = (q_cnt == fill);
        if (q_cnt == fill) begin
          fill_next  = '0;
          state_next = ST_IDLE;
        end else begin
          q_re       = 1'b1;
          q_raddr    = q_cnt[QW-1:0];
          q_cnt_next = q_cnt + FW'(1);
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
module testbench;
  import rcsm_pkg::*;

  localparam int SLOT_COUNT = 16;
  localparam int GQ_DEPTH = 32;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]        kind;
    logic [OUT_AW-1:0] addr;
    logic              full;
    logic              empty;
    logic              last;
  } slot_result_t;

  logic              clk;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic [OP_W-1:0]   operation = '0;
  logic [IDX_W-1:0]  slot_index = '0;
  logic [IN_AW-1:0]  new_address = '0;
  logic              busy;
  logic              strobe;
  logic [1:0]        result_kind;
  logic [OUT_AW-1:0] address;
  logic              queue_full;
  logic              queue_empty;
  logic              last;

  // predicted block state
  logic [IN_AW-1:0]  slot_mem [SLOT_COUNT];
  logic [IN_AW-1:0]  garbage_mem [GQ_DEPTH];
  int                garbage_count = 0;
  slot_result_t      pending_results [$];

  logic [IN_AW-1:0]  addr_pool [8];
  bit                no_gaps = 1'b0;
  int                mismatches = 0;
  int                cycle_count = 0;

  reference_count_slot_manager_core #(
    .SLOTS(SLOT_COUNT),
    .GARBAGE_DEPTH(GQ_DEPTH),
    .ADDRESS_WIDTH(32)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .operation(operation),
    .slot_index(slot_index),
    .new_address(new_address),
    .strobe(strobe),
    .result_kind(result_kind),
    .address(address),
    .queue_full(queue_full),
    .queue_empty(queue_empty),
    .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic apply_slot_request(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                                    input logic [IN_AW-1:0] addr);
    slot_result_t r;
    logic [IN_AW-1:0] old;
    int holders;
    r = '0;
    r.last = 1'b1;
    case (op)
      OP_REASSIGN: begin
        old = slot_mem[idx];
        holders = 0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (slot_mem[i] == old) holders++;
        end
        // old address dies when this slot was its only holder
        if (old != '0 && holders == 1) begin
          if (garbage_count < GQ_DEPTH) begin
            garbage_mem[garbage_count] = old;
            garbage_count++;
          end else begin
            r.full = 1'b1;
          end
        end
        slot_mem[idx] = addr;
        r.kind = KIND_STATUS;
        r.addr = addr;
        pending_results.push_back(r);
      end
      OP_COLLECT: begin
        r.kind = KIND_COLLECT;
        if (garbage_count == 0) begin
          r.empty = 1'b1;
          pending_results.push_back(r);
        end else begin
          for (int i = 0; i < garbage_count; i++) begin
            r.addr = garbage_mem[i];
            r.last = (i == garbage_count - 1);
            pending_results.push_back(r);
          end
          garbage_count = 0;
        end
      end
      OP_READ: begin
        r.kind = KIND_SLOT;
        r.addr = slot_mem[idx];
        pending_results.push_back(r);
      end
      default: begin
      end
    endcase
  endtask

  task automatic flag_mismatch(input string what, input slot_result_t want,
                               input slot_result_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: exp kind=%0d addr=%h full=%b empty=%b last=%b", $time, what,
               want.kind, want.addr, want.full, want.empty, want.last,
               "  act kind=%0d addr=%h full=%b empty=%b last=%b",
               got.kind, got.addr, got.full, got.empty, got.last);
  endtask

  always @(posedge clk) begin
    slot_result_t got;
    slot_result_t want;
    if (!rst && strobe) begin
      got = '{result_kind, address, queue_full, queue_empty, last};
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected result", '0, got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) flag_mismatch("result mismatch", want, got);
      end
    end
  end

  task automatic send_request(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                              input logic [IN_AW-1:0] addr);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    operation <= op;
    slot_index <= idx;
    new_address <= addr;
    do @(posedge clk); while (busy);
    apply_slot_request(op, idx, addr);
  endtask

  task automatic test_reset_state();
    send_request(OP_COLLECT, 4'd0, '0);
    send_request(OP_READ, 4'd0, '1);
    send_request(OP_READ, 4'd15, '0);
  endtask

  task automatic test_shared_addresses();
    send_request(OP_REASSIGN, 4'd0, 32'hFFFF_FFFF);
    send_request(OP_REASSIGN, 4'd15, 32'h0000_0001);
    send_request(OP_REASSIGN, 4'd1, 32'hFFFF_FFFF);
    // same address, still held elsewhere
    send_request(OP_REASSIGN, 4'd0, 32'hFFFF_FFFF);
    // same address, sole holder: queued then counted again
    send_request(OP_REASSIGN, 4'd15, 32'h0000_0001);
    send_request(OP_REASSIGN, 4'd0, 32'h0000_0000);
    send_request(OP_REASSIGN, 4'd1, 32'h8000_0000);
    send_request(OP_REASSIGN, 4'd2, 32'h0000_0000);
    send_request(OP_READ, 4'd0, '0);
    send_request(OP_READ, 4'd1, '0);
    send_request(OP_READ, 4'd15, '0);
    send_request(OP_COLLECT, 4'd0, '0);
    send_request(OP_COLLECT, 4'd0, '0);
    send_request(OP_REASSIGN, 4'd15, 32'h0000_0000);
    send_request(OP_COLLECT, 4'd0, '0);
  endtask

  task automatic test_unused_opcode();
    send_request(OP_UNUSED, 4'd15, 32'hFFFF_FFFF);
    send_request(OP_UNUSED, 4'd0, 32'h0000_0000);
    send_request(OP_READ, 4'd1, '0);
    send_request(OP_COLLECT, 4'd0, '0);
  endtask

  task automatic test_queue_overflow(input bit back_to_back);
    logic [IN_AW-1:0] fresh;
    no_gaps = back_to_back;
    send_request(OP_COLLECT, 4'($urandom), $urandom());
    for (int k = 0; k < 50; k++) begin
      fresh = $urandom();
      while (fresh == '0) fresh = $urandom();
      send_request(OP_REASSIGN, 4'(k % SLOT_COUNT), fresh);
      if ($urandom_range(0, 9) == 0)
        send_request(OP_READ, 4'($urandom_range(0, SLOT_COUNT - 1)), $urandom());
    end
    send_request(OP_COLLECT, 4'($urandom), $urandom());
    no_gaps = 1'b0;
  endtask

  task automatic test_random_mix(input int count);
    int pick;
    logic [IN_AW-1:0] a;
    for (int i = 0; i < 8; i++) addr_pool[i] = $urandom();
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 39) == 0) no_gaps = ~no_gaps;
      if ($urandom_range(0, 49) == 0) addr_pool[$urandom_range(0, 7)] = $urandom();
      pick = $urandom_range(0, 9);
      if (pick == 0) a = '0;
      else if (pick <= 6) a = addr_pool[$urandom_range(0, 7)];
      else a = $urandom();
      pick = $urandom_range(0, 99);
      if (pick < 60) send_request(OP_REASSIGN, 4'($urandom), a);
      else if (pick < 80) send_request(OP_READ, 4'($urandom), a);
      else if (pick < 94) send_request(OP_COLLECT, 4'($urandom), a);
      else send_request(OP_UNUSED, 4'($urandom), a);
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < SLOT_COUNT; i++) slot_mem[i] = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_shared_addresses();
    test_unused_opcode();
    test_queue_overflow(1'b0);
    test_random_mix(330);
    test_queue_overflow(1'b1);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SLOT_COUNT + 16) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/rcsm_pkg.sv
sv/reference_count_slot_manager_core.sv
verif/testbench.sv
